>>> design/bunch_crossing_classifier_macros.svh
// Assertion helpers shared by the classifier RTL.
`ifndef BUNCH_CROSSING_CLASSIFIER_MACROS_SVH
`define BUNCH_CROSSING_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bunch crossing classifier check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bunch crossing classifier check failed");

`endif

>>> design/bcc_pkg.sv
`timescale 1ns / 1ps

package bcc_pkg;

  localparam int unsigned RANGES_DEF = 16;
  localparam int unsigned SLOTS_DEF  = 4096;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned LB_W       = 16;
  localparam int unsigned BCID_W     = 12;
  localparam int unsigned RIDX_W     = 4;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned RIU_W      = 5;
  localparam int unsigned GAP_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned FLAG_W     = 3;

  // Bit positions in a slot's flag word.
  localparam int unsigned FL_COLL = 0;
  localparam int unsigned FL_B1   = 1;
  localparam int unsigned FL_B2   = 2;

  localparam logic [GAP_W-1:0] GAP_RESET = 4'd8;
  localparam logic [CNT_W-1:0] EDGE_NONE = 13'h1FFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY = 2'd0,
    MODE_RANGE = 2'd1,
    MODE_BITS  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd1;

  // Per-range bookkeeping row: type counts and unpaired edges.
  typedef struct packed {
    logic [CNT_W-1:0] b2_last;
    logic [CNT_W-1:0] b2_first;
    logic [CNT_W-1:0] b1_last;
    logic [CNT_W-1:0] b1_first;
    logic [CNT_W-1:0] cnt_b2;
    logic [CNT_W-1:0] cnt_b1;
    logic [CNT_W-1:0] cnt_coll;
  } info_t;

  localparam info_t INFO_RESET = '{
    b2_last:  EDGE_NONE,
    b2_first: EDGE_NONE,
    b1_last:  EDGE_NONE,
    b1_first: EDGE_NONE,
    cnt_b2:   '0,
    cnt_b1:   '0,
    cnt_coll: '0
  };

  // Range bound row.
  typedef struct packed {
    logic            stable;
    logic [LB_W-1:0] hi;
    logic [LB_W-1:0] lo;
  } bound_t;

endpackage

>>> design/bcc_ram.sv
`timescale 1ns / 1ps

module bcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bunch_crossing_classifier.sv
// Query: the bounds of each range are read and compared in turn, then the slots within L of
//   the queried one are swept, where L is max(isolation_gap-1, 2), and the result is registered.
// Range write: stored as the item is accepted. Bit set: read-modify-write of the shared flag memory.
// Throughput: one item at a time; the single-port flag memory sets the query length.
// Reset: asynchronous, active low; then a clearing pass over all RANGES*SLOTS entries
//   (65536 by default) zeroes the flag memory while input stays stalled.
`timescale 1ns / 1ps

`include "bunch_crossing_classifier_macros.svh"

module bunch_crossing_classifier #(
  parameter int unsigned RANGES = bcc_pkg::RANGES_DEF,
  parameter int unsigned SLOTS  = bcc_pkg::SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bcc_pkg::MODE_W-1:0]   mode_i,
  input  logic [bcc_pkg::LB_W-1:0]     lumi_block_i,
  input  logic [bcc_pkg::BCID_W-1:0]   bcid_i,
  input  logic [bcc_pkg::RIDX_W-1:0]   range_index_i,
  input  logic [bcc_pkg::LB_W-1:0]     range_low_i,
  input  logic [bcc_pkg::LB_W-1:0]     range_high_i,
  input  logic                         stable_in_i,
  input  logic                         set_colliding_i,
  input  logic                         set_beam1_i,
  input  logic                         set_beam2_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         range_found_o,
  output logic                         is_colliding_o,
  output logic                         is_beam1_o,
  output logic                         is_beam2_o,
  output logic                         colliding_first_o,
  output logic                         unpaired_first_o,
  output logic                         unpaired_last_o,
  output logic                         unpaired_isolated_o,
  output logic                         stable_beam_o,
  output logic [bcc_pkg::CNT_W-1:0]    colliding_count_o,
  output logic [bcc_pkg::CNT_W-1:0]    beam1_count_o,
  output logic [bcc_pkg::CNT_W-1:0]    beam2_count_o,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned RW     = (RANGES > 1) ? $clog2(RANGES) : 1;
  localparam int unsigned CW     = $clog2(RANGES + 1);
  localparam int unsigned FDEPTH = RANGES * SLOTS;
  localparam int unsigned FAW    = $clog2(FDEPTH);
  localparam int unsigned INFO_W = $bits(bcc_pkg::info_t);
  localparam int unsigned BND_W  = $bits(bcc_pkg::bound_t);
  localparam int unsigned GW     = bcc_pkg::GAP_W;

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_SRCH_RD  = 9'b000000100,
    S_SRCH_CMP = 9'b000001000,
    S_SWEEP    = 9'b000010000,
    S_DRAIN    = 9'b000100000,
    S_DONE     = 9'b001000000,
    S_WR_RD    = 9'b010000000,
    S_WR_WR    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers. The port never pushes back.
  logic [bcc_pkg::RIU_W-1:0] riu_q;
  logic [GW-1:0]             gap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      riu_q <= '0;
      gap_q <= bcc_pkg::GAP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bcc_pkg::CFG_RANGES: riu_q <= cfg_data_i;
        bcc_pkg::CFG_GAP:    gap_q <= cfg_data_i[GW-1:0];
        default: ;
      endcase
    end
  end

  // Input transfer and its classification.
  logic in_xfer;
  logic ri_ok;
  logic bcid_ok;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign ri_ok      = (32'(range_index_i) < RANGES);
  assign bcid_ok    = (32'(bcid_i) < SLOTS);

  // Number of ranges to search, capped at the table size.
  logic [CW-1:0] limit;
  assign limit = (32'(riu_q) > RANGES) ? CW'(RANGES) : CW'(riu_q);

  // Sweep half-width: wide enough for both the isolation window and the
  // two-slot look-back of the first-colliding test.
  logic [GW-1:0] sweep_lim;
  assign sweep_lim = (gap_q >= 4'd4) ? (gap_q - 4'd1) : 4'd2;

  // Latched item and sequencer registers.
  logic [bcc_pkg::LB_W-1:0]   lb_q;
  logic [bcc_pkg::BCID_W-1:0] bcid_q;
  logic [RW-1:0]              r_q;
  logic [2:0]                 req_q;
  logic [FAW-1:0]             base_q;
  logic [CW-1:0]              idx_q;
  logic                       found_q;
  logic signed [4:0]          off_q;
  logic signed [4:0]          pend_off_q;
  logic                       pend_vld_q;
  logic [bcc_pkg::FLAG_W-1:0] center_q;
  logic [bcc_pkg::FLAG_W-1:0] near_q;
  logic                       prev_coll_q;
  logic [FAW-1:0]             clr_q;
  logic [RANGES-1:0]          info_vld_q;
  logic                       info_v_q;

  // Memory ports.
  logic                       flag_we, flag_re;
  logic [FAW-1:0]             flag_addr;
  logic [bcc_pkg::FLAG_W-1:0] flag_wdata, flag_rdata;
  logic                       info_we, info_re;
  logic [RW-1:0]              info_addr;
  bcc_pkg::info_t             info_wdata, info_rdata, info_cur;
  logic                       bnd_we, bnd_re;
  logic [RW-1:0]              bnd_addr;
  bcc_pkg::bound_t            bnd_wdata, bnd_rdata;

  bcc_ram #(.WIDTH(bcc_pkg::FLAG_W), .DEPTH(FDEPTH)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .re_i    (flag_re),
    .addr_i  (flag_addr),
    .wdata_i (flag_wdata),
    .rdata_o (flag_rdata)
  );

  bcc_ram #(.WIDTH(INFO_W), .DEPTH(RANGES)) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .re_i    (info_re),
    .addr_i  (info_addr),
    .wdata_i (info_wdata),
    .rdata_o (info_rdata)
  );

  bcc_ram #(.WIDTH(BND_W), .DEPTH(RANGES)) u_bound_ram (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .re_i    (bnd_re),
    .addr_i  (bnd_addr),
    .wdata_i (bnd_wdata),
    .rdata_o (bnd_rdata)
  );

  // A range row that was never touched reads as its reset contents.
  assign info_cur = info_v_q ? info_rdata : bcc_pkg::INFO_RESET;

  // Slot currently addressed by the sweep, and whether it lies in the table.
  logic signed [13:0] slot_s;
  logic               slot_ok;
  assign slot_s  = $signed({2'b00, bcid_q}) + 14'(off_q);
  assign slot_ok = !slot_s[13] && (int'(slot_s) < int'(SLOTS));

  // Classification of the neighbor whose read data arrives this cycle.
  logic [3:0] pend_abs;
  logic       pend_near;
  logic       pend_prev;
  assign pend_abs  = pend_off_q[4] ? 4'(-pend_off_q) : 4'(pend_off_q);
  assign pend_near = (pend_off_q != 5'sd0) && (pend_abs < gap_q);
  assign pend_prev = (pend_off_q == -5'sd1) || (pend_off_q == -5'sd2);

  // Search compare on the registered bound row.
  logic hit;
  assign hit = (lb_q >= bnd_rdata.lo) && (lb_q <= bnd_rdata.hi);

  // Read-modify-write of one slot's bits and its range's bookkeeping.
  logic [2:0]                 new_bits;
  logic [bcc_pkg::CNT_W-1:0]  bc13;
  bcc_pkg::info_t             info_upd;
  assign new_bits = req_q & ~flag_rdata;
  assign bc13     = {1'b0, bcid_q};

  always_comb begin
    info_upd = info_cur;
    if (new_bits[bcc_pkg::FL_COLL]) begin
      info_upd.cnt_coll = info_cur.cnt_coll + 1'b1;
    end
    if (new_bits[bcc_pkg::FL_B1]) begin
      info_upd.cnt_b1 = info_cur.cnt_b1 + 1'b1;
      if (bc13 < info_cur.b1_first) begin
        info_upd.b1_first = bc13;
      end
      if ((info_cur.b1_last == bcc_pkg::EDGE_NONE) || (bc13 > info_cur.b1_last)) begin
        info_upd.b1_last = bc13;
      end
    end
    if (new_bits[bcc_pkg::FL_B2]) begin
      info_upd.cnt_b2 = info_cur.cnt_b2 + 1'b1;
      if (bc13 < info_cur.b2_first) begin
        info_upd.b2_first = bc13;
      end
      if ((info_cur.b2_last == bcc_pkg::EDGE_NONE) || (bc13 > info_cur.b2_last)) begin
        info_upd.b2_last = bc13;
      end
    end
  end

  // Memory port control. The flag memory has a single port, so the clearing
  // pass, the sweep and the bit-set path take turns through the sequencer.
  always_comb begin
    flag_we    = 1'b0;
    flag_re    = 1'b0;
    flag_addr  = base_q + FAW'(bcid_q);
    flag_wdata = flag_rdata | req_q;
    info_we    = 1'b0;
    info_re    = 1'b0;
    info_addr  = r_q;
    info_wdata = info_upd;
    bnd_we     = 1'b0;
    bnd_re     = 1'b0;
    bnd_addr   = RW'(idx_q);
    bnd_wdata  = '{stable: stable_in_i, hi: range_high_i, lo: range_low_i};
    case (state_q)
      S_CLEAR: begin
        flag_we    = 1'b1;
        flag_addr  = clr_q;
        flag_wdata = '0;
      end
      S_IDLE: begin
        bnd_addr = RW'(range_index_i);
        bnd_we   = in_xfer && (mode_i == bcc_pkg::MODE_RANGE) && ri_ok;
      end
      S_SRCH_RD: begin
        bnd_re = 1'b1;
      end
      S_SRCH_CMP: begin
        info_addr = RW'(idx_q);
        info_re   = hit;
      end
      S_SWEEP: begin
        flag_addr = base_q + FAW'(slot_s[12:0]);
        flag_re   = slot_ok;
      end
      S_WR_RD: begin
        flag_re = 1'b1;
        info_re = 1'b1;
      end
      S_WR_WR: begin
        flag_we = 1'b1;
        info_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == FAW'(FDEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (mode_i)
            bcc_pkg::MODE_QUERY: state_d = (limit == '0) ? S_DONE : S_SRCH_RD;
            bcc_pkg::MODE_BITS:  state_d = (ri_ok && bcid_ok) ? S_WR_RD : S_IDLE;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD: state_d = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (hit) begin
          state_d = S_SWEEP;
        end else if (idx_q + 1'b1 == limit) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_SWEEP: begin
        if (off_q == $signed({1'b0, sweep_lim})) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      S_WR_RD: state_d = S_WR_WR;
      S_WR_WR: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      info_vld_q <= '0;
      pend_vld_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
        end
        S_IDLE: begin
          found_q <= 1'b0;
        end
        S_SRCH_CMP: begin
          found_q <= hit;
        end
        S_WR_WR: begin
          info_vld_q[r_q] <= 1'b1;
        end
        default: ;
      endcase
      pend_vld_q <= (state_q == S_SWEEP) && slot_ok;
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        lb_q   <= lumi_block_i;
        bcid_q <= bcid_i;
        r_q    <= RW'(range_index_i);
        req_q  <= {set_beam2_i, set_beam1_i, set_colliding_i};
        base_q <= FAW'(32'(range_index_i) * SLOTS);
        idx_q  <= '0;
      end
      S_SRCH_CMP: begin
        idx_q       <= idx_q + 1'b1;
        r_q         <= RW'(idx_q);
        base_q      <= FAW'(32'(idx_q) * SLOTS);
        info_v_q    <= info_vld_q[RW'(idx_q)];
        off_q       <= -$signed({1'b0, sweep_lim});
        center_q    <= '0;
        near_q      <= '0;
        prev_coll_q <= 1'b0;
      end
      S_WR_RD: begin
        info_v_q <= info_vld_q[r_q];
      end
      default: ;
    endcase
    if (state_q == S_SWEEP) begin
      off_q      <= off_q + 5'sd1;
      pend_off_q <= off_q;
    end
    // Fold in the neighbor read issued in the previous cycle.
    if (pend_vld_q) begin
      if (pend_off_q == 5'sd0) begin
        center_q <= flag_rdata;
      end
      if (pend_near) begin
        near_q <= near_q | flag_rdata;
      end
      if (pend_prev && flag_rdata[bcc_pkg::FL_COLL]) begin
        prev_coll_q <= 1'b1;
      end
    end
  end

  // Final classification from the gathered slot bits.
  logic c_coll, c_b1, c_b2;
  logic [bcc_pkg::FLAG_W-1:0] iso_mask;
  logic res_ufirst, res_ulast;
  assign c_coll = center_q[bcc_pkg::FL_COLL];
  assign c_b1   = center_q[bcc_pkg::FL_B1];
  assign c_b2   = center_q[bcc_pkg::FL_B2];

  always_comb begin
    iso_mask = '0;
    iso_mask[bcc_pkg::FL_COLL] = 1'b1;
    iso_mask[bcc_pkg::FL_B2]   = c_b1;
    iso_mask[bcc_pkg::FL_B1]   = c_b2;
    if (c_b1) begin
      res_ufirst = (info_cur.b1_first == bc13);
      res_ulast  = (info_cur.b1_last == bc13);
    end else if (c_b2) begin
      res_ufirst = (info_cur.b2_first == bc13);
      res_ulast  = (info_cur.b2_last == bc13);
    end else begin
      res_ufirst = 1'b0;
      res_ulast  = 1'b0;
    end
  end

  // Output register: holds a finished result until the consumer takes it.
  logic out_valid_q;
  logic out_load;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      range_found_o       <= found_q;
      is_colliding_o      <= found_q && c_coll;
      is_beam1_o          <= found_q && c_b1;
      is_beam2_o          <= found_q && c_b2;
      colliding_first_o   <= found_q && c_coll && !prev_coll_q;
      unpaired_first_o    <= found_q && res_ufirst;
      unpaired_last_o     <= found_q && res_ulast;
      unpaired_isolated_o <= found_q && (c_b1 || c_b2) && ((near_q & iso_mask) == '0);
      stable_beam_o       <= found_q && bnd_rdata.stable;
      colliding_count_o   <= found_q ? info_cur.cnt_coll : '0;
      beam1_count_o       <= found_q ? info_cur.cnt_b1 : '0;
      beam2_count_o       <= found_q ? info_cur.cnt_b2 : '0;
    end
  end

  // Items are taken only by an idle sequencer.
  `BCC_ASSERT_IMP(a_accept_idle, in_valid_i && !in_stall_o, state_q == S_IDLE)
  // The search never addresses a range beyond the searched count.
  `BCC_ASSERT_IMP(a_search_bound, state_q == S_SRCH_RD, idx_q < limit)
  // A miss always produces a result with the found flag low.
  `BCC_ASSERT_NXT(a_miss_result, out_load && !found_q, out_valid_o && !range_found_o)
  // The sweep never strays beyond its configured half-width.
  `BCC_ASSERT_IMP(a_sweep_span, state_q == S_SWEEP,
                  (off_q <= $signed({1'b0, sweep_lim})) &&
                  (off_q >= -$signed({1'b0, sweep_lim})))

endmodule

>>> verif/tb_bunch_crossing_classifier.sv
`timescale 1ns / 1ps

module tb_bunch_crossing_classifier;

  localparam int NRANGE = 16;
  localparam int NSLOT = 4096;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT = 3000000;

  typedef logic [bcc_pkg::MODE_W-1:0]     mode_t;
  typedef logic [bcc_pkg::LB_W-1:0]       lb_t;
  typedef logic [bcc_pkg::BCID_W-1:0]     bcid_t;
  typedef logic [bcc_pkg::RIDX_W-1:0]     ridx_t;
  typedef logic [bcc_pkg::CNT_W-1:0]      cnt_t;
  typedef logic [bcc_pkg::FLAG_W-1:0]     flag_t;
  typedef logic [bcc_pkg::RIU_W-1:0]      riu_t;
  typedef logic [bcc_pkg::GAP_W-1:0]      gap_t;
  typedef logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data_t;

  // One input transfer with every field of the input channel.
  typedef struct {
    bcc_pkg::mode_e mode;
    lb_t            lumi;
    bcid_t          bcid;
    ridx_t          ridx;
    lb_t            lo;
    lb_t            hi;
    logic           stable;
    logic           coll;
    logic           b1;
    logic           b2;
  } crossing_item_t;

  // One classification result, in the order of the output ports.
  typedef struct {
    logic found;
    logic coll;
    logic b1;
    logic b2;
    logic coll_first;
    logic up_first;
    logic up_last;
    logic isolated;
    logic stable;
    cnt_t n_coll;
    cnt_t n_b1;
    cnt_t n_b2;
  } class_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  mode_t     mode_d = '0;
  lb_t       lumi_d = '0;
  bcid_t     bcid_d = '0;
  ridx_t     ridx_d = '0;
  lb_t       lo_d = '0;
  lb_t       hi_d = '0;
  logic      stable_d = 1'b0;
  logic      coll_d = 1'b0;
  logic      b1_d = 1'b0;
  logic      b2_d = 1'b0;

  logic      out_valid;
  logic      out_stall = 1'b0;
  logic      got_found;
  logic      got_coll;
  logic      got_b1;
  logic      got_b2;
  logic      got_coll_first;
  logic      got_up_first;
  logic      got_up_last;
  logic      got_isolated;
  logic      got_stable;
  cnt_t      got_n_coll;
  cnt_t      got_n_b1;
  cnt_t      got_n_b2;

  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_data = '0;

  always #5 clk_i = ~clk_i;

  bunch_crossing_classifier dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .mode_i              (mode_d),
    .lumi_block_i        (lumi_d),
    .bcid_i              (bcid_d),
    .range_index_i       (ridx_d),
    .range_low_i         (lo_d),
    .range_high_i        (hi_d),
    .stable_in_i         (stable_d),
    .set_colliding_i     (coll_d),
    .set_beam1_i         (b1_d),
    .set_beam2_i         (b2_d),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .range_found_o       (got_found),
    .is_colliding_o      (got_coll),
    .is_beam1_o          (got_b1),
    .is_beam2_o          (got_b2),
    .colliding_first_o   (got_coll_first),
    .unpaired_first_o    (got_up_first),
    .unpaired_last_o     (got_up_last),
    .unpaired_isolated_o (got_isolated),
    .stable_beam_o       (got_stable),
    .colliding_count_o   (got_n_coll),
    .beam1_count_o       (got_n_b1),
    .beam2_count_o       (got_n_b2),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  // Shadow copy of the classifier state. Flag bits are indexed by FL_COLL, FL_B1 and FL_B2.
  flag_t slot_map [NRANGE][NSLOT];
  lb_t   bound_lo [NRANGE];
  lb_t   bound_hi [NRANGE];
  logic  bound_stable [NRANGE];
  cnt_t  type_cnt [NRANGE][3];
  // Unpaired edges per range: beam 1 first, beam 1 last, beam 2 first, beam 2 last.
  cnt_t  edge_slot [NRANGE][4];
  riu_t  ranges_used = '0;
  gap_t  iso_gap = bcc_pkg::GAP_RESET;

  crossing_item_t pending_items [$];
  class_result_t  awaited [$];
  crossing_item_t on_bus;
  int  errors = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  quiet = 1'b0;
  bit  in_done = 1'b0;
  int  cycles = 0;
  int  bases [3];

  initial begin
    for (int r = 0; r < NRANGE; r++) begin
      for (int s = 0; s < NSLOT; s++) slot_map[r][s] = '0;
      for (int k = 0; k < 3; k++) type_cnt[r][k] = '0;
      for (int k = 0; k < 4; k++) edge_slot[r][k] = bcc_pkg::EDGE_NONE;
      bound_lo[r] = '0;
      bound_hi[r] = '0;
      bound_stable[r] = 1'b0;
    end
  end

  function automatic void queue_item(crossing_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Slots outside the table read as empty, which also covers the search below slot 0.
  function automatic flag_t flags_at(int r, int s);
    if (s < 0 || s >= NSLOT) return '0;
    return slot_map[r][s];
  endfunction

  // Applies one accepted transfer to the shadow state and returns whether it yields a result.
  function automatic bit classify_crossing(crossing_item_t it, output class_result_t res);
    int r;
    int s;
    int lim;
    bit hit;
    flag_t f;
    flag_t fm1;
    flag_t fm2;
    flag_t mask;
    flag_t req;
    res = '{default: '0};
    r = int'(it.ridx);
    s = int'(it.bcid);
    case (it.mode)
      bcc_pkg::MODE_RANGE: begin
        bound_lo[r] = it.lo;
        bound_hi[r] = it.hi;
        bound_stable[r] = it.stable;
        return 1'b0;
      end
      bcc_pkg::MODE_BITS: begin
        req = '0;
        req[bcc_pkg::FL_COLL] = it.coll;
        req[bcc_pkg::FL_B1] = it.b1;
        req[bcc_pkg::FL_B2] = it.b2;
        for (int k = 0; k < 3; k++) begin
          if (req[k] && !slot_map[r][s][k]) begin
            slot_map[r][s][k] = 1'b1;
            type_cnt[r][k]++;
            if (k > 0) begin
              if (edge_slot[r][(k-1)*2] == bcc_pkg::EDGE_NONE || s < edge_slot[r][(k-1)*2])
                edge_slot[r][(k-1)*2] = cnt_t'(s);
              if (edge_slot[r][(k-1)*2+1] == bcc_pkg::EDGE_NONE ||
                  s > edge_slot[r][(k-1)*2+1])
                edge_slot[r][(k-1)*2+1] = cnt_t'(s);
            end
          end
        end
        return 1'b0;
      end
      bcc_pkg::MODE_NONE: return 1'b0;
      default: ;
    endcase
    // First range, lowest index first, whose inclusive bounds hold the lumi block.
    lim = (int'(ranges_used) > NRANGE) ? NRANGE : int'(ranges_used);
    hit = 1'b0;
    for (int i = 0; i < lim && !hit; i++) begin
      if (it.lumi >= bound_lo[i] && it.lumi <= bound_hi[i]) begin
        r = i;
        hit = 1'b1;
      end
    end
    if (!hit) return 1'b1;
    f = flags_at(r, s);
    fm1 = flags_at(r, s - 1);
    fm2 = flags_at(r, s - 2);
    res.found = 1'b1;
    res.coll = f[bcc_pkg::FL_COLL];
    res.b1 = f[bcc_pkg::FL_B1];
    res.b2 = f[bcc_pkg::FL_B2];
    res.coll_first = f[bcc_pkg::FL_COLL] && !fm1[bcc_pkg::FL_COLL] && !fm2[bcc_pkg::FL_COLL];
    if (f[bcc_pkg::FL_B1]) begin
      res.up_first = (edge_slot[r][0] == s);
      res.up_last = (edge_slot[r][1] == s);
    end else if (f[bcc_pkg::FL_B2]) begin
      res.up_first = (edge_slot[r][2] == s);
      res.up_last = (edge_slot[r][3] == s);
    end
    // An unpaired slot is isolated when no colliding or opposite-beam slot lies closer than
    // the gap on either side.
    if (f[bcc_pkg::FL_B1] || f[bcc_pkg::FL_B2]) begin
      mask = '0;
      mask[bcc_pkg::FL_COLL] = 1'b1;
      mask[bcc_pkg::FL_B2] = f[bcc_pkg::FL_B1];
      mask[bcc_pkg::FL_B1] = f[bcc_pkg::FL_B2];
      res.isolated = 1'b1;
      for (int d = 1; d < int'(iso_gap); d++) begin
        if ((flags_at(r, s - d) & mask) != '0 || (flags_at(r, s + d) & mask) != '0)
          res.isolated = 1'b0;
      end
    end
    res.stable = bound_stable[r];
    res.n_coll = type_cnt[r][bcc_pkg::FL_COLL];
    res.n_b1 = type_cnt[r][bcc_pkg::FL_B1];
    res.n_b2 = type_cnt[r][bcc_pkg::FL_B2];
    return 1'b1;
  endfunction

  task automatic check_field(string name, cnt_t want, cnt_t have);
    if (want !== have) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, have);
      errors++;
    end
  endtask

  // Input acceptance and result checking share the rising edge; a result can never belong
  // to the transfer accepted at the same edge.
  always @(posedge clk_i) begin
    class_result_t res;
    class_result_t want;
    if (rst_ni) begin
      cycles++;
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $display("%0t: result transfer expected none, actual range_found %0d",
                   $time, got_found);
          errors++;
        end else begin
          want = awaited.pop_front();
          check_field("range_found", cnt_t'(want.found), cnt_t'(got_found));
          check_field("is_colliding", cnt_t'(want.coll), cnt_t'(got_coll));
          check_field("is_beam1", cnt_t'(want.b1), cnt_t'(got_b1));
          check_field("is_beam2", cnt_t'(want.b2), cnt_t'(got_b2));
          check_field("colliding_first", cnt_t'(want.coll_first), cnt_t'(got_coll_first));
          check_field("unpaired_first", cnt_t'(want.up_first), cnt_t'(got_up_first));
          check_field("unpaired_last", cnt_t'(want.up_last), cnt_t'(got_up_last));
          check_field("unpaired_isolated", cnt_t'(want.isolated), cnt_t'(got_isolated));
          check_field("stable_beam", cnt_t'(want.stable), cnt_t'(got_stable));
          check_field("colliding_count", want.n_coll, got_n_coll);
          check_field("beam1_count", want.n_b1, got_n_b1);
          check_field("beam2_count", want.n_b2, got_n_b2);
        end
      end
      if (in_valid && !in_stall) begin
        in_done = 1'b1;
        if (classify_crossing(on_bus, res)) awaited.insert(awaited.size(), res);
      end
    end
  end

  // Driver: a held transfer stays put until accepted, then the next one comes from the queue,
  // sometimes after a random idle burst.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_done)) begin
      in_done = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        on_bus = pending_items.pop_front();
        mode_d <= on_bus.mode;
        lumi_d <= on_bus.lumi;
        bcid_d <= on_bus.bcid;
        ridx_d <= on_bus.ridx;
        lo_d <= on_bus.lo;
        hi_d <= on_bus.hi;
        stable_d <= on_bus.stable;
        coll_d <= on_bus.coll;
        b1_d <= on_bus.b1;
        b2_d <= on_bus.b2;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap = int'($urandom_range(1, 19));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && rst_ni && $urandom_range(0, 7) == 0) out_gap = int'($urandom_range(1, 19));
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic crossing_item_t noise_item();
    crossing_item_t it;
    it.mode = bcc_pkg::mode_e'($urandom_range(0, 3));
    it.lumi = lb_t'($urandom);
    it.bcid = bcid_t'($urandom);
    it.ridx = ridx_t'($urandom);
    it.lo = lb_t'($urandom);
    it.hi = lb_t'($urandom);
    it.stable = 1'($urandom);
    it.coll = 1'($urandom);
    it.b1 = 1'($urandom);
    it.b2 = 1'($urandom);
    return it;
  endfunction

  function automatic crossing_item_t make_item(bcc_pkg::mode_e m, int lumi, int bcid, int ridx,
                                               int lo, int hi, bit st, bit c, bit p1, bit p2);
    crossing_item_t it;
    it = noise_item();
    it.mode = m;
    it.lumi = lb_t'(lumi);
    it.bcid = bcid_t'(bcid);
    it.ridx = ridx_t'(ridx);
    it.lo = lb_t'(lo);
    it.hi = lb_t'(hi);
    it.stable = st;
    it.coll = c;
    it.b1 = p1;
    it.b2 = p2;
    return it;
  endfunction

  // Random traffic clustered around a few slot windows so that neighbors and edges interact.
  function automatic crossing_item_t random_item();
    crossing_item_t it;
    int pick;
    int lo;
    it = noise_item();
    it.bcid = bcid_t'(bases[$urandom_range(0, 2)] + int'($urandom_range(0, 47)));
    pick = int'($urandom_range(0, 99));
    if (pick < 45) begin
      it.mode = bcc_pkg::MODE_QUERY;
      if ($urandom_range(0, 9) != 0) it.lumi = lb_t'($urandom_range(0, 1100));
    end else if (pick < 87) begin
      it.mode = bcc_pkg::MODE_BITS;
    end else if (pick < 96) begin
      it.mode = bcc_pkg::MODE_RANGE;
      if ($urandom_range(0, 9) != 0) begin
        lo = int'($urandom_range(0, 1023));
        it.lo = lb_t'(lo);
        it.hi = lb_t'(lo + int'($urandom_range(0, 200)));
        if ($urandom_range(0, 7) == 0) it.hi = lb_t'(lo - 1);
      end
    end else begin
      it.mode = bcc_pkg::MODE_NONE;
    end
    return it;
  endfunction

  task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
    @(negedge clk_i);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == bcc_pkg::CFG_RANGES) ranges_used = riu_t'(value);
    else if (idx == bcc_pkg::CFG_GAP) iso_gap = gap_t'(value);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued transfer is accepted and every result has arrived, then lets
  // a trailing bit update or range write finish inside the block.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || awaited.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    bases[0] = 0;
    bases[1] = NSLOT - 48;
    bases[2] = int'($urandom_range(0, NSLOT - 48));
    for (int i = 0; i < count; i++) queue_item(random_item());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every range entry is written before any is searched. Range 3 has its low bound above
    // its high bound and range 15 spans all lumi blocks.
    for (int r = 0; r < NRANGE; r++)
      queue_item(make_item(bcc_pkg::MODE_RANGE, 0, 0, r, r * 64, r * 64 + 63, r[0], 0, 0, 0));
    pending_items[3].lo = 16'd300;
    pending_items[3].hi = 16'd100;
    pending_items[15].lo = 16'd0;
    pending_items[15].hi = 16'hFFFF;
    // With no ranges in use nothing is found.
    queue_item(make_item(bcc_pkg::MODE_QUERY, 10, 5, 0, 0, 0, 0, 0, 0, 0));
    drain();
    write_reg(bcc_pkg::CFG_RANGES, 5'd16);
    write_reg(bcc_pkg::CFG_GAP, 5'd8);

    // Directed: table edges, a colliding train, isolated and crowded unpaired bunches,
    // a bit set twice, ignored mode, and lumi blocks matching nothing but the catch-all range.
    queue_item(make_item(bcc_pkg::MODE_BITS, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    queue_item(make_item(bcc_pkg::MODE_BITS, 0, 4095, 0, 0, 0, 0, 0, 1, 1));
    queue_item(make_item(bcc_pkg::MODE_BITS, 0, 1, 0, 0, 0, 0, 1, 0, 0));
    queue_item(make_item(bcc_pkg::MODE_BITS, 0, 1, 0, 0, 0, 0, 1, 0, 0));
    queue_item(make_item(bcc_pkg::MODE_BITS, 0, 100, 0, 0, 0, 0, 0, 1, 0));
    queue_item(make_item(bcc_pkg::MODE_BITS, 0, 200, 0, 0, 0, 0, 0, 0, 1));
    queue_item(make_item(bcc_pkg::MODE_BITS, 0, 203, 0, 0, 0, 0, 0, 1, 0));
    queue_item(make_item(bcc_pkg::MODE_NONE, 5, 0, 0, 0, 0, 0, 1, 1, 1));
    queue_item(make_item(bcc_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(bcc_pkg::MODE_QUERY, 63, 1, 0, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(bcc_pkg::MODE_QUERY, 7, 4095, 0, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(bcc_pkg::MODE_QUERY, 7, 100, 0, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(bcc_pkg::MODE_QUERY, 7, 200, 0, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(bcc_pkg::MODE_QUERY, 7, 203, 0, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(bcc_pkg::MODE_QUERY, 200, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(bcc_pkg::MODE_QUERY, 65535, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    write_reg(bcc_pkg::CFG_GAP, 5'd1);
    random_phase(400);
    drain();
    write_reg(bcc_pkg::CFG_RANGES, 5'd5);
    write_reg(bcc_pkg::CFG_GAP, 5'd3);
    random_phase(400);
    drain();
    write_reg(bcc_pkg::CFG_RANGES, 5'd1);
    write_reg(bcc_pkg::CFG_GAP, 5'd8);
    random_phase(400);
    drain();
    write_reg(bcc_pkg::CFG_RANGES, cfg_data_t'($urandom_range(0, 16)));
    write_reg(bcc_pkg::CFG_GAP, cfg_data_t'($urandom_range(1, 8)));
    random_phase(400);
    drain();
    // Final stretch runs without any idling on either side.
    write_reg(bcc_pkg::CFG_RANGES, 5'd16);
    write_reg(bcc_pkg::CFG_GAP, 5'd8);
    quiet = 1'b1;
    random_phase(400);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
